// ----- sv/fcca_pkg.sv -----
// Shared types and constants of the cluster chain allocator.
// Used by fcca_ctrl and fat_cluster_chain_allocator_top; depends on nothing.
package fcca_pkg;

	localparam int CLUSTER_COUNT_DEF = 65536;
	localparam int OWNER_BITS_DEF    = 16;
	localparam int NCNT_W            = 24;

	localparam logic [31:0] ENTRY_FREE = 32'h0000_0000;
	localparam logic [31:0] ENTRY_EOC  = 32'h0FFF_FFFF;
	localparam logic [31:0] ENTRY_RES0 = 32'h0FFF_FFF0;
	localparam logic [31:0] ENTRY_RES1 = 32'h08FF_FFFF;

	localparam logic [2:0] OP_FORMAT  = 3'd0;
	localparam logic [2:0] OP_ALLOC   = 3'd1;
	localparam logic [2:0] OP_REALLOC = 3'd2;
	localparam logic [2:0] OP_FREE    = 3'd3;
	localparam logic [2:0] OP_CSIZE   = 3'd4;
	localparam logic [2:0] OP_QUERY   = 3'd5;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BROKEN = 2'd2;

	localparam logic REG_SHIFT = 1'b0;
	localparam logic REG_ROOT  = 1'b1;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [15:0] cluster;
		logic [15:0] stop_cluster;
		logic [31:0] size_bytes;
		logic [15:0] owner;
	} fcca_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] first_out;
		logic [31:0] chain_bytes;
		logic        is_free;
		logic [15:0] owner_out;
		logic [31:0] next_entry;
	} fcca_rsp_t;

endpackage

// ----- sv/fcca_ram.sv -----
// Single-port RAM with registered read data, one access a cycle.
// Generic; used for the next-cluster table and the owner table.
module fcca_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end
endmodule

// ----- sv/fcca_ctrl.sv -----
// Sequencer of the allocator: walks chains and searches the table through
// the two RAM ports, one entry per step. Depends on fcca_pkg.
module fcca_ctrl #(
	parameter int CLUSTER_COUNT = 65536,
	parameter int OWNER_BITS    = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  fcca_pkg::fcca_req_t              req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output fcca_pkg::fcca_rsp_t              rsp,
	input  logic [3:0]                       cluster_shift,
	input  logic [15:0]                      root_cluster,
	output logic                             nx_we,
	output logic [$clog2(CLUSTER_COUNT)-1:0] nx_addr,
	output logic [31:0]                      nx_wdata,
	input  logic [31:0]                      nx_rdata,
	output logic                             ow_we,
	output logic [$clog2(CLUSTER_COUNT)-1:0] ow_addr,
	output logic [OWNER_BITS-1:0]            ow_wdata,
	input  logic [OWNER_BITS-1:0]            ow_rdata
);
	import fcca_pkg::*;

	localparam int CW = $clog2(CLUSTER_COUNT);
	localparam logic [31:0]   CC32     = 32'(CLUSTER_COUNT);
	localparam logic [CW:0]   CC_CNT   = (CW+1)'(CLUSTER_COUNT);
	localparam logic [CW-1:0] LAST_IDX = CW'(CLUSTER_COUNT - 1);
	localparam logic [CW-1:0] FIRST_IX = CW'(2);
	localparam logic [CW-1:0] SRCH_LEN = CW'(CLUSTER_COUNT - 2);

	typedef enum logic [4:0] {
		S_CLR, S_ROOT, S_IDLE, S_DISP, S_SRD, S_SCK, S_TAKE, S_LINK,
		S_RCHK, S_RLOOP, S_RLCK, S_RLCK2, S_RTCK, S_FRD, S_FCK,
		S_CRD, S_CCK, S_QCK, S_FIN
	} state_t;

	state_t              state_q;
	logic                fmt_q;
	logic [CW-1:0]       clr_q;
	logic [2:0]          op_q;
	logic [15:0]         cl_q;
	logic [15:0]         last_q;
	logic [OWNER_BITS-1:0] own_q;
	logic [NCNT_W-1:0]   n_q;
	logic [3:0]          sh_q;
	logic [CW-1:0]       hint_q;
	logic [CW-1:0]       sidx_q;
	logic [CW-1:0]       rem_q;
	logic [CW-1:0]       got_q;
	logic [CW-1:0]       cur_q;
	logic                took_q;
	logic [31:0]         c_q;
	logic [31:0]         e_q;
	logic [CW:0]         cnt_q;
	fcca_rsp_t           res_q;
	fcca_rsp_t           out_q;
	logic                ovalid_q;

	logic [3:0]          sh_in;
	logic [32:0]         sz_sum;
	logic [32:0]         sz_shr;
	logic [NCNT_W-1:0]   n_in;
	logic [CW-1:0]       start_idx;
	logic [35:0]         bytes_w;
	logic [31:0]         own32_in;
	logic [31:0]         own32_rd;
	logic                root_ok;

	function automatic logic usable(input logic [31:0] x);
		return (x >= 32'd2) && (x < CC32);
	endfunction

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = ovalid_q;
	assign rsp       = out_q;

	// Size to cluster count: round up, at least one cluster
	assign sh_in   = (cluster_shift < 4'd9) ? 4'd9 : cluster_shift;
	assign sz_sum  = {1'b0, req.size_bytes} + ((33'd1 << sh_in) - 33'd1);
	assign sz_shr  = sz_sum >> sh_in;
	assign n_in    = (sz_shr[NCNT_W-1:0] == '0) ? NCNT_W'(1) : sz_shr[NCNT_W-1:0];

	assign start_idx = (hint_q >= FIRST_IX) ? hint_q : FIRST_IX;
	assign bytes_w   = 36'(cnt_q) << sh_q;
	assign own32_in  = {16'h0000, req.owner};
	assign own32_rd  = 32'(ow_rdata);
	assign root_ok   = usable({16'h0000, root_cluster});

	always_comb begin
		nx_we    = 1'b0;
		nx_addr  = cur_q;
		nx_wdata = ENTRY_FREE;
		ow_we    = 1'b0;
		ow_addr  = cur_q;
		ow_wdata = own_q;
		case (state_q)
			S_CLR: begin
				nx_we   = 1'b1;
				nx_addr = clr_q;
				if (fmt_q && clr_q == CW'(0)) begin
					nx_wdata = ENTRY_RES0;
				end else if (fmt_q && clr_q == CW'(1)) begin
					nx_wdata = ENTRY_RES1;
				end
			end
			S_ROOT: begin
				nx_we    = 1'b1;
				nx_addr  = CW'(root_cluster);
				nx_wdata = ENTRY_EOC;
				ow_we    = 1'b1;
				ow_addr  = CW'(root_cluster);
			end
			S_DISP: begin
				nx_addr = CW'(cl_q);
				ow_addr = CW'(cl_q);
			end
			S_SRD: nx_addr = sidx_q;
			S_TAKE: begin
				nx_we    = 1'b1;
				nx_addr  = got_q;
				nx_wdata = ENTRY_EOC;
				ow_we    = 1'b1;
				ow_addr  = got_q;
			end
			S_LINK: begin
				nx_we    = 1'b1;
				nx_wdata = 32'(got_q);
			end
			S_RLCK: nx_addr = CW'(nx_rdata);
			S_RTCK: begin
				ow_we = 1'b1;
				if (nx_rdata != ENTRY_EOC) begin
					nx_we    = 1'b1;
					nx_wdata = ENTRY_EOC;
				end
			end
			S_FRD, S_CRD: nx_addr = CW'(c_q);
			S_FCK: begin
				nx_addr = CW'(c_q);
				nx_we   = (nx_rdata != ENTRY_FREE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLR;
			fmt_q    <= 1'b0;
			clr_q    <= '0;
			hint_q   <= FIRST_IX;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && rsp_ready && state_q != S_FIN) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == LAST_IDX) begin
						if (fmt_q && root_ok) begin
							state_q <= S_ROOT;
						end else if (fmt_q) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_ROOT: state_q <= S_FIN;
				S_IDLE: begin
					if (req_valid) begin
						op_q    <= req.opcode;
						cl_q    <= req.cluster;
						last_q  <= req.stop_cluster;
						own_q   <= own32_in[OWNER_BITS-1:0];
						n_q     <= n_in;
						sh_q    <= sh_in;
						took_q  <= 1'b0;
						cnt_q   <= '0;
						c_q     <= {16'h0000, req.cluster};
						res_q   <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					case (op_q)
						OP_FORMAT: begin
							fmt_q   <= 1'b1;
							clr_q   <= '0;
							state_q <= S_CLR;
						end
						OP_ALLOC: begin
							sidx_q  <= start_idx;
							rem_q   <= SRCH_LEN;
							state_q <= S_SRD;
						end
						OP_REALLOC: begin
							res_q.first_out <= cl_q;
							if (!usable({16'h0000, cl_q})) begin
								res_q.status <= ST_BROKEN;
								state_q      <= S_FIN;
							end else begin
								state_q <= S_RCHK;
							end
						end
						OP_FREE:  state_q <= S_FRD;
						OP_CSIZE: state_q <= S_CRD;
						OP_QUERY: begin
							state_q <= ({16'h0000, cl_q} < CC32) ? S_QCK : S_FIN;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_SRD: state_q <= S_SCK;
				S_SCK: begin
					if (nx_rdata == ENTRY_FREE) begin
						got_q   <= sidx_q;
						hint_q  <= sidx_q;
						state_q <= S_TAKE;
					end else if (rem_q == CW'(1)) begin
						res_q.status <= ST_FULL;
						state_q      <= S_FIN;
					end else begin
						sidx_q  <= (sidx_q == LAST_IDX) ? FIRST_IX : sidx_q + CW'(1);
						rem_q   <= rem_q - CW'(1);
						state_q <= S_SRD;
					end
				end
				S_TAKE: begin
					if (op_q == OP_ALLOC && !took_q) begin
						took_q          <= 1'b1;
						cur_q           <= got_q;
						res_q.first_out <= 16'(got_q);
						if (n_q == NCNT_W'(1)) begin
							state_q <= S_FIN;
						end else begin
							n_q     <= n_q - NCNT_W'(1);
							sidx_q  <= start_idx;
							rem_q   <= SRCH_LEN;
							state_q <= S_SRD;
						end
					end else begin
						state_q <= S_LINK;
					end
				end
				S_LINK: begin
					cur_q <= got_q;
					if (op_q == OP_REALLOC) begin
						n_q     <= n_q - NCNT_W'(1);
						state_q <= S_RLOOP;
					end else if (n_q == NCNT_W'(1)) begin
						state_q <= S_FIN;
					end else begin
						n_q     <= n_q - NCNT_W'(1);
						sidx_q  <= start_idx;
						rem_q   <= SRCH_LEN;
						state_q <= S_SRD;
					end
				end
				S_RCHK: begin
					if (nx_rdata == ENTRY_FREE) begin
						res_q.status <= ST_BROKEN;
						state_q      <= S_FIN;
					end else begin
						own_q   <= ow_rdata;
						cur_q   <= CW'(cl_q);
						n_q     <= n_q - NCNT_W'(1);
						state_q <= S_RLOOP;
					end
				end
				S_RLOOP: state_q <= (n_q == '0) ? S_RTCK : S_RLCK;
				S_RLCK: begin
					e_q <= nx_rdata;
					if (nx_rdata == ENTRY_EOC) begin
						sidx_q  <= start_idx;
						rem_q   <= SRCH_LEN;
						state_q <= S_SRD;
					end else if (usable(nx_rdata)) begin
						state_q <= S_RLCK2;
					end else begin
						res_q.status <= ST_BROKEN;
						state_q      <= S_FIN;
					end
				end
				S_RLCK2: begin
					if (nx_rdata != ENTRY_FREE) begin
						cur_q   <= CW'(e_q);
						n_q     <= n_q - NCNT_W'(1);
						state_q <= S_RLOOP;
					end else begin
						res_q.status <= ST_BROKEN;
						state_q      <= S_FIN;
					end
				end
				S_RTCK: begin
					// cut the old tail, then free it
					if (nx_rdata != ENTRY_EOC) begin
						c_q     <= nx_rdata;
						cnt_q   <= '0;
						state_q <= S_FRD;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FRD: begin
					if (cnt_q == CC_CNT || !usable(c_q)) begin
						res_q.status <= ST_BROKEN;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_FCK;
					end
				end
				S_FCK: begin
					if (nx_rdata == ENTRY_FREE) begin
						res_q.status <= ST_BROKEN;
						state_q      <= S_FIN;
					end else if (nx_rdata == ENTRY_EOC) begin
						state_q <= S_FIN;
					end else begin
						c_q     <= nx_rdata;
						cnt_q   <= cnt_q + (CW+1)'(1);
						state_q <= S_FRD;
					end
				end
				S_CRD: begin
					if (c_q == {16'h0000, last_q}) begin
						res_q.chain_bytes <= (bytes_w[35:32] != 4'h0) ? 32'hFFFF_FFFF
							: bytes_w[31:0];
						state_q <= S_FIN;
					end else if (cnt_q >= CC_CNT || !usable(c_q)) begin
						res_q.status <= ST_BROKEN;
						state_q      <= S_FIN;
					end else begin
						state_q <= S_CCK;
					end
				end
				S_CCK: begin
					if (!usable(nx_rdata)) begin
						res_q.status <= ST_BROKEN;
						state_q      <= S_FIN;
					end else begin
						c_q     <= nx_rdata;
						cnt_q   <= cnt_q + (CW+1)'(1);
						state_q <= S_CRD;
					end
				end
				S_QCK: begin
					res_q.next_entry <= nx_rdata;
					res_q.is_free    <= (nx_rdata == ENTRY_FREE);
					res_q.owner_out  <= own32_rd[15:0];
					state_q          <= S_FIN;
				end
				S_FIN: begin
					fmt_q <= 1'b0;
					// hold the result until the output register is free
					if (!ovalid_q || rsp_ready) begin
						out_q    <= res_q;
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/fat_cluster_chain_allocator_top.sv -----
// Cluster chain allocator: next-cluster table, owner table, sequencer and
// configuration registers. Depends on fcca_pkg, fcca_ram and fcca_ctrl.
//
// Usage: one request item (req, req_valid/req_ready) carries an opcode:
// format, allocate, reallocate, free, chain size or query. Each request
// gives exactly one response item (rsp, rsp_valid/rsp_ready).
// The sequencer owns a single-port next table RAM, so table accesses are
// made one at a time. A query reads at dispatch, checks, then registers its
// result; a free-cluster search reads, then checks each entry from the hint;
// each chain step of free or chain size is a read and a check, an existing
// step of reallocate a loop and two check states, each added cluster a
// search, take, link and loop. Format sweeps the table. One request is in
// work at a time; req_ready is high only while the sequencer is idle.
// After reset the table is cleared by a pass over every entry during
// which no request is taken; APB writes are taken at any time.
// A finished response waits in the output register while the receiver
// stalls; the next request may be accepted meanwhile but its response is
// held until the register frees.
module fat_cluster_chain_allocator_top #(
	parameter int CLUSTER_COUNT = fcca_pkg::CLUSTER_COUNT_DEF,
	parameter int OWNER_BITS    = fcca_pkg::OWNER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  fcca_pkg::fcca_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output fcca_pkg::fcca_rsp_t rsp,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import fcca_pkg::*;

	localparam int CW = $clog2(CLUSTER_COUNT);

	logic [3:0]            shift_q;
	logic [15:0]           root_q;
	logic                  nx_we;
	logic [CW-1:0]         nx_addr;
	logic [31:0]           nx_wdata;
	logic [31:0]           nx_rdata;
	logic                  ow_we;
	logic [CW-1:0]         ow_addr;
	logic [OWNER_BITS-1:0] ow_wdata;
	logic [OWNER_BITS-1:0] ow_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ROOT) ? {16'h0000, root_q} : {28'h0, shift_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= 4'd12;
			root_q  <= 16'd2;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_SHIFT) begin
				shift_q <= pwdata[3:0];
			end else begin
				root_q <= pwdata[15:0];
			end
		end
	end

	fcca_ctrl #(
		.CLUSTER_COUNT (CLUSTER_COUNT),
		.OWNER_BITS    (OWNER_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.rsp           (rsp),
		.cluster_shift (shift_q),
		.root_cluster  (root_q),
		.nx_we         (nx_we),
		.nx_addr       (nx_addr),
		.nx_wdata      (nx_wdata),
		.nx_rdata      (nx_rdata),
		.ow_we         (ow_we),
		.ow_addr       (ow_addr),
		.ow_wdata      (ow_wdata),
		.ow_rdata      (ow_rdata)
	);

	fcca_ram #(
		.DEPTH (CLUSTER_COUNT),
		.WIDTH (32)
	) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.addr  (nx_addr),
		.wdata (nx_wdata),
		.rdata (nx_rdata)
	);

	fcca_ram #(
		.DEPTH (CLUSTER_COUNT),
		.WIDTH (OWNER_BITS)
	) u_owner_ram (
		.clk   (clk),
		.we    (ow_we),
		.addr  (ow_addr),
		.wdata (ow_wdata),
		.rdata (ow_rdata)
	);
endmodule
